[src/stk_pkg.sv]
// ----------------------------------------------------------------------------
// Stack package
// Shared payload types, operation and status codes, and the command and
// status structs between the stack controller and datapath.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int MODE_BITS   = 3;
  localparam int DATA_BITS   = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  localparam logic [MODE_BITS-1:0] MODE_PUSH = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_POP  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_SWAP = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ROT  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_RROT = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FEW   = 2'd3;

  // ring address selects
  localparam logic [2:0] ADDR_TOP    = 3'd0;
  localparam logic [2:0] ADDR_NEXT   = 3'd1;
  localparam logic [2:0] ADDR_PREV   = 3'd2;
  localparam logic [2:0] ADDR_BOTTOM = 3'd3;
  localparam logic [2:0] ADDR_BELOW  = 3'd4;

  // write data selects
  localparam logic [1:0] WD_PUSH  = 2'd0;
  localparam logic [1:0] WD_RDATA = 2'd1;
  localparam logic [1:0] WD_TMP   = 2'd2;

  // top pointer / count adjustment
  localparam logic [1:0] ADJ_HOLD = 2'd0;
  localparam logic [1:0] ADJ_INC  = 2'd1;
  localparam logic [1:0] ADJ_DEC  = 2'd2;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [DATA_BITS-1:0] push_word;
  } stk_req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]   popped_word;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  count;
  } stk_rsp_t;

  typedef struct packed {
    logic                   load;
    logic                   rd_en;
    logic [2:0]             rd_sel;
    logic                   wr_en;
    logic [2:0]             wr_sel;
    logic [1:0]             wd_sel;
    logic                   tmp_load;
    logic                   res_load;
    logic [STATUS_BITS-1:0] res_status;
    logic                   res_pop;
    logic [1:0]             top_op;
    logic [1:0]             cnt_op;
  } stk_cmd_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 empty;
    logic                 full;
    logic                 few;
  } stk_stat_t;

endpackage

[src/stk_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module stk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/stk_dp.sv]
// ----------------------------------------------------------------------------
// Stack datapath
// Ring buffer, top pointer, word count, held transaction, swap temporary and result registers.
// ----------------------------------------------------------------------------
module stk_dp
  import stk_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  stk_req_t  req,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat,
  output stk_rsp_t  rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [AW-1:0] TOP_MAX = AW'(CAPACITY - 1);

  stk_req_t               item;
  logic [AW-1:0]          top;
  logic [CW-1:0]          count;
  logic [WORD_BITS-1:0]   tmp;
  logic [DATA_BITS-1:0]   res_popped;
  logic [STATUS_BITS-1:0] res_status;

  logic [AW-1:0]        top_inc, top_dec, bottom, below, raddr, waddr;
  logic [SW-1:0]        below_sum, bottom_sum;
  logic [WORD_BITS-1:0] rdata, wdata;

  assign top_inc    = (top == TOP_MAX) ? '0 : top + AW'(1);
  assign top_dec    = (top == '0) ? TOP_MAX : top - AW'(1);
  assign below_sum  = SW'(top) + SW'(count);
  assign bottom_sum = below_sum - SW'(1);
  assign below      = (below_sum >= CAP_S) ? AW'(below_sum - CAP_S) : AW'(below_sum);
  assign bottom     = (bottom_sum >= CAP_S) ? AW'(bottom_sum - CAP_S) : AW'(bottom_sum);

  function automatic logic [AW-1:0] pick(input logic [2:0] sel, input logic [AW-1:0] t,
                                         input logic [AW-1:0] n, input logic [AW-1:0] p,
                                         input logic [AW-1:0] b, input logic [AW-1:0] w);
    logic [AW-1:0] a;
    case (sel)
      ADDR_TOP:    a = t;
      ADDR_NEXT:   a = n;
      ADDR_PREV:   a = p;
      ADDR_BOTTOM: a = b;
      ADDR_BELOW:  a = w;
      default:     a = t;
    endcase
    return a;
  endfunction

  assign raddr = pick(cmd.rd_sel, top, top_inc, top_dec, bottom, below);
  assign waddr = pick(cmd.wr_sel, top, top_inc, top_dec, bottom, below);

  always_comb begin
    case (cmd.wd_sel)
      WD_PUSH:  wdata = WORD_BITS'(item.push_word);
      WD_RDATA: wdata = rdata;
      WD_TMP:   wdata = tmp;
      default:  wdata = rdata;
    endcase
  end

  stk_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) ram_i (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= '0;
      count <= '0;
    end else begin
      case (cmd.top_op)
        ADJ_INC: top <= top_inc;
        ADJ_DEC: top <= top_dec;
        default: top <= top;
      endcase
      case (cmd.cnt_op)
        ADJ_INC: count <= count + CW'(1);
        ADJ_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (cmd.tmp_load) begin
      tmp <= rdata;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_popped <= cmd.res_pop ? DATA_BITS'(rdata) : '0;
    end
  end

  assign stat.mode  = item.mode;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(CAPACITY));
  assign stat.few   = (count < CW'(2));

  assign rsp.popped_word = res_popped;
  assign rsp.status      = res_status;
  assign rsp.count       = COUNT_BITS'(count);

endmodule

[src/stk_ctrl.sv]
// ----------------------------------------------------------------------------
// Stack controller
// Sequences the ring buffer accesses of each operation and the result strobe.
// ----------------------------------------------------------------------------
module stk_ctrl
  import stk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  stk_stat_t stat,
  output stk_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_POP  = 4'd2;
  localparam logic [3:0] S_SW1  = 4'd3;
  localparam logic [3:0] S_SW2  = 4'd4;
  localparam logic [3:0] S_SW3  = 4'd5;
  localparam logic [3:0] S_ROT  = 4'd6;
  localparam logic [3:0] S_RROT = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE) && (state != S_RESP);
  assign done = (state == S_RESP);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE, S_RESP: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EXEC: begin
        state_next     = S_RESP;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_DONE;
        case (stat.mode)
          MODE_PUSH: begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ADDR_PREV;
              cmd.wd_sel = WD_PUSH;
              cmd.top_op = ADJ_DEC;
              cmd.cnt_op = ADJ_INC;
            end
          end
          MODE_POP: begin
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = ADDR_TOP;
              state_next   = S_POP;
            end
          end
          MODE_SWAP, MODE_ROT, MODE_RROT: begin
            if (stat.few) begin
              cmd.res_status = ST_FEW;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_en    = 1'b1;
              if (stat.mode == MODE_RROT) begin
                cmd.rd_sel = ADDR_BOTTOM;
                state_next = S_RROT;
              end else begin
                cmd.rd_sel = ADDR_TOP;
                state_next = (stat.mode == MODE_SWAP) ? S_SW1 : S_ROT;
              end
            end
          end
          default: ;
        endcase
      end
      S_POP: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_DONE;
        cmd.res_pop    = 1'b1;
        cmd.top_op     = ADJ_INC;
        cmd.cnt_op     = ADJ_DEC;
        state_next     = S_RESP;
      end
      S_SW1: begin
        cmd.tmp_load = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = ADDR_NEXT;
        state_next   = S_SW2;
      end
      S_SW2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ADDR_TOP;
        cmd.wd_sel = WD_RDATA;
        state_next = S_SW3;
      end
      S_SW3: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = ADDR_NEXT;
        cmd.wd_sel     = WD_TMP;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_DONE;
        state_next     = S_RESP;
      end
      S_ROT: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = ADDR_BELOW;
        cmd.wd_sel     = WD_RDATA;
        cmd.top_op     = ADJ_INC;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_DONE;
        state_next     = S_RESP;
      end
      S_RROT: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = ADDR_PREV;
        cmd.wd_sel     = WD_RDATA;
        cmd.top_op     = ADJ_DEC;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_DONE;
        state_next     = S_RESP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/stack_with_swap_and_rotate.sv]
// ----------------------------------------------------------------------------
// Stack with swap and rotate
// Bounded word stack in a ring buffer: push, pop, swap, rotate, reverse rotate.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low;
//   req carries the mode and the word to push. Exactly one result follows on
//   rsp, marked by done for a single cycle; the receiver cannot stall it.
//   Push, refused operations and unknown modes go from the execute state
//   to the done cycle; pop passes through S_POP, the rotations through
//   S_ROT or S_RROT, and swap through S_SW1, S_SW2 and S_SW3. busy is low
//   during the done cycle, so a new transaction can be taken there; the
//   length of a transaction is set by the single read and single write port
//   of the ring buffer RAM (swap needs two reads and two writes).
//   rsp.count is the number of words held after the operation.
//   Reset clears the top pointer and count; stored words need no clearing,
//   as only written entries are read.
// ----------------------------------------------------------------------------
module stack_with_swap_and_rotate
  import stk_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  stk_req_t req,
  output logic     done,
  output stk_rsp_t rsp
);

  stk_cmd_t  cmd;
  stk_stat_t stat;

  stk_ctrl ctrl_i (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  stk_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) dp_i (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

[src/stk_chk.sv]
// ----------------------------------------------------------------------------
// Stack port checker
// Port-level properties of the stack, bound to the top level.
// ----------------------------------------------------------------------------
module stk_chk
  import stk_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input stk_rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding work");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EMPTY) |-> (rsp.count == '0 && rsp.popped_word == '0))
    else $error("empty status with words held or data returned");

  a_few_words: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FEW) |-> (rsp.count < COUNT_BITS'(2)))
    else $error("fewer-than-two status with two or more words held");

endmodule

bind stack_with_swap_and_rotate stk_chk chk_i (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

[test/stack_with_swap_and_rotate_tb.sv]
// ----------------------------------------------------------------------------
// Stack with swap and rotate testbench
// Drives push, pop, swap, rotate, reverse rotate and unknown-mode transactions with random
// gaps, keeps a shadow copy of the ring, top pointer and count, and checks
// every response field against it in order of acceptance.
// ----------------------------------------------------------------------------
module stack_with_swap_and_rotate_tb;
  import stk_pkg::*;

  localparam int RING_DEPTH   = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_WAIT   = 10;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_FIRST = MODE_RROT + 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LAST  = 3'd7;

  class stack_shadow;
    logic [DATA_BITS-1:0]  ring [RING_DEPTH];
    logic [3:0]            top_pos;
    logic [COUNT_BITS-1:0] held;
    stk_rsp_t              expected_q [$];
    int                    errors;

    function new();
      top_pos = '0;
      held    = '0;
      errors  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_command(stk_req_t cmd);
      stk_rsp_t             r;
      logic [3:0]           pos;
      logic [DATA_BITS-1:0] tmp;
      r        = '0;
      r.status = ST_DONE;
      case (cmd.mode)
        MODE_PUSH: begin
          if (held == RING_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            top_pos       = top_pos - 4'd1;
            ring[top_pos] = cmd.push_word;
            held          = held + 5'd1;
          end
        end
        MODE_POP: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped_word = ring[top_pos];
            top_pos       = top_pos + 4'd1;
            held          = held - 5'd1;
          end
        end
        MODE_SWAP: begin
          if (held < 2) begin
            r.status = ST_FEW;
          end else begin
            pos           = top_pos + 4'd1;
            tmp           = ring[top_pos];
            ring[top_pos] = ring[pos];
            ring[pos]     = tmp;
          end
        end
        MODE_ROT: begin
          if (held < 2) begin
            r.status = ST_FEW;
          end else begin
            pos       = top_pos + held[3:0];
            ring[pos] = ring[top_pos];
            top_pos   = top_pos + 4'd1;
          end
        end
        MODE_RROT: begin
          if (held < 2) begin
            r.status = ST_FEW;
          end else begin
            pos           = top_pos + held[3:0] - 4'd1;
            top_pos       = top_pos - 4'd1;
            ring[top_pos] = ring[pos];
          end
        end
        default: ;
      endcase
      r.count = held;
      expected_q.push_back(r);
    endfunction

    function void check_response(stk_rsp_t got);
      stk_rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (got.popped_word !== exp_rsp.popped_word) begin
        $display("%0t: popped_word expected %h got %h", $time, exp_rsp.popped_word,
                 got.popped_word);
        errors++;
      end
      if (got.status !== exp_rsp.status) begin
        $display("%0t: status expected %0d got %0d", $time, exp_rsp.status, got.status);
        errors++;
      end
      if (got.count !== exp_rsp.count) begin
        $display("%0t: count expected %0d got %0d", $time, exp_rsp.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  stk_req_t req   = '0;
  logic     done;
  stk_rsp_t rsp;

  stack_shadow shadow = new();
  bit          idle_on = 1'b1;
  int          cycles  = 0;

  stack_with_swap_and_rotate #(
    .CAPACITY (RING_DEPTH),
    .WORD_BITS(DATA_BITS)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        shadow.note_command(req);
      end
      if (done) begin
        shadow.check_response(rsp);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // returns on the edge that took the transaction, or after a random idle gap that follows it
  task automatic send_cmd(logic [MODE_BITS-1:0] mode, logic [DATA_BITS-1:0] word);
    start         <= 1'b1;
    req.mode      <= mode;
    req.push_word <= word;
    do @(posedge clk); while (busy);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_BITS-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom();
  endfunction

  task automatic run_random(int n);
    bit filling;
    int phase_left;
    int r;
    filling    = 1'b1;
    phase_left = $urandom_range(20, 80);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      idle_on = !(i >= 900 && i < 1300);
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 3)
        send_cmd(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), pick_word());
      else if (r < 11)
        send_cmd(MODE_SWAP, pick_word());
      else if (r < 19)
        send_cmd(MODE_ROT, pick_word());
      else if (r < 27)
        send_cmd(MODE_RROT, pick_word());
      else if ($urandom_range(0, 99) < (filling ? 70 : 30))
        send_cmd(MODE_PUSH, pick_word());
      else
        send_cmd(MODE_POP, pick_word());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack
    send_cmd(MODE_POP, '1);
    send_cmd(MODE_SWAP, '0);
    send_cmd(MODE_ROT, '0);
    send_cmd(MODE_SPARE_LAST, '1);
    // single word
    send_cmd(MODE_PUSH, '0);
    send_cmd(MODE_SWAP, '0);
    send_cmd(MODE_ROT, '0);
    send_cmd(MODE_RROT, '0);
    // fill to capacity, then a refused push, rotations, swap, an unknown mode and a pop on a full ring
    for (int i = 1; i < RING_DEPTH - 1; i++) send_cmd(MODE_PUSH, $urandom());
    send_cmd(MODE_PUSH, '1);
    send_cmd(MODE_PUSH, 32'h5a5a_a5a5);
    send_cmd(MODE_ROT, '0);
    send_cmd(MODE_RROT, '0);
    send_cmd(MODE_SWAP, '0);
    send_cmd(MODE_SPARE_FIRST, '0);
    send_cmd(MODE_POP, '0);

    run_random(RANDOM_ITEMS);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
